[rtl/stack_with_middle_ops_defines.svh]
// Assertion macros shared by the RTL of the stack block.
`ifndef STACK_WITH_MIDDLE_OPS_DEFINES_SVH
`define STACK_WITH_MIDDLE_OPS_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SWMO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SWMO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/swmo_pkg.sv]
package swmo_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [REQ_W-1:0] REQ_PUSH     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP      = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ_MID = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_MID  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Shift command broadcast to every cell of the row.
  typedef struct packed {
    logic push;       // every cell takes its upper neighbour, cell 0 takes the new word
    logic shift_left; // cells take their lower neighbour
    logic from_mid;   // restrict the left shift to cells at or below the middle
  } cell_ctrl_t;

endpackage

[rtl/swmo_cell.sv]
module swmo_cell #(
  parameter int unsigned IW  = 6,
  parameter int unsigned IDX = 0
) (
  input  logic                          clk_i,
  input  swmo_pkg::cell_ctrl_t          ctrl_i,
  input  logic [IW-1:0]                 mid_idx_i,
  input  logic [swmo_pkg::DATA_W-1:0]   left_i,   // cell nearer the top
  input  logic [swmo_pkg::DATA_W-1:0]   right_i,  // cell nearer the bottom
  output logic [swmo_pkg::DATA_W-1:0]   data_o,
  output logic [swmo_pkg::DATA_W-1:0]   mid_o
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [swmo_pkg::DATA_W-1:0] data_q;
  logic                        shift_here;

  assign shift_here = ctrl_i.shift_left && (!ctrl_i.from_mid || (MyIdx >= mid_idx_i));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      data_q <= left_i;
    end else if (shift_here) begin
      data_q <= right_i;
    end
  end

  assign data_o = data_q;
  // Contributes to the middle read bus only when this cell holds the middle.
  assign mid_o  = (MyIdx == mid_idx_i) ? data_q : '0;

endmodule

[rtl/stack_with_middle_ops.sv]
// A request is held in the request register, then executes into the cell row and the
// output register once the output is free; no new request is taken until it executes.
// The row of cells shifts all at once, so this does not depend on the fill level.
// Reset clears the element count and handshake state; cell contents are left undefined
// and need no clearing pass, since only written cells are ever read.
`include "stack_with_middle_ops_defines.svh"

module stack_with_middle_ops #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [swmo_pkg::IN_DATA_W-1:0]      s_tdata,   // [31:0] push_value
  input  logic [swmo_pkg::REQ_W-1:0]          s_tuser,   // [1:0] req_type
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [swmo_pkg::OUT_DATA_W-1:0]     m_tdata,   // [31:0] result_value,
                                                         // [38:32] element_count, [39] zero
  output logic [swmo_pkg::STATUS_W-1:0]       m_tuser    // [1:0] status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int DW = swmo_pkg::DATA_W;

  logic                              pend_q;
  logic [swmo_pkg::REQ_W-1:0]        req_q;
  logic [DW-1:0]                     val_q;
  logic [CW-1:0]                     n_q, n_d;
  logic                              out_valid_q;
  logic [DW-1:0]                     out_result_q, result;
  logic [swmo_pkg::STATUS_W-1:0]     out_status_q, status;
  logic [swmo_pkg::COUNT_W-1:0]      out_count_q;
  logic [CW+swmo_pkg::COUNT_W-1:0]   count_ext;

  logic                  exec, full, empty;
  logic [CW-1:0]         nm1, nm1_half;
  logic [IW-1:0]         mid_idx;
  swmo_pkg::cell_ctrl_t  ctrl;
  logic [DW-1:0]         cell_data [CAPACITY];
  logic [DW-1:0]         cell_mid  [CAPACITY];
  logic [DW-1:0]         mid_word;

  assign s_tready = !pend_q;
  assign exec     = pend_q && (!out_valid_q || m_tready);
  assign full     = (n_q == CW'(CAPACITY));
  assign empty    = (n_q == '0);

  // Middle is floor(n/2) from the bottom; cell 0 is the top, so index ceil(n/2)-1.
  assign nm1      = n_q - CW'(1);
  assign nm1_half = nm1 >> 1;
  assign mid_idx  = nm1_half[IW-1:0];

  always_comb begin
    mid_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      mid_word = mid_word | cell_mid[i];
    end
  end

  always_comb begin
    ctrl   = '0;
    n_d    = n_q;
    result = '0;
    status = swmo_pkg::ST_DONE;
    if (req_q == swmo_pkg::REQ_PUSH) begin
      if (full) begin
        status = swmo_pkg::ST_FULL;
      end else begin
        ctrl.push = exec;
        n_d       = n_q + CW'(1);
      end
    end else if (empty) begin
      status = swmo_pkg::ST_EMPTY;
    end else begin
      case (req_q)
        swmo_pkg::REQ_POP: begin
          result          = cell_data[0];
          ctrl.shift_left = exec;
          n_d             = nm1;
        end
        swmo_pkg::REQ_READ_MID: begin
          result = mid_word;
        end
        swmo_pkg::REQ_DEL_MID: begin
          ctrl.shift_left = exec;
          ctrl.from_mid   = 1'b1;
          n_d             = nm1;
        end
        default: begin
          result = '0;
        end
      endcase
    end
  end

  assign count_ext = {{swmo_pkg::COUNT_W{1'b0}}, n_d};

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DW-1:0] left_w, right_w;
    if (g == 0) begin : g_top
      assign left_w = val_q;
    end else begin : g_inner
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_bottom
      assign right_w = '0;
    end else begin : g_upper
      assign right_w = cell_data[g+1];
    end
    swmo_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .mid_idx_i (mid_idx),
      .left_i    (left_w),
      .right_i   (right_w),
      .data_o    (cell_data[g]),
      .mid_o     (cell_mid[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pend_q <= 1'b1;
      end else if (exec) begin
        pend_q <= 1'b0;
      end
      if (exec) begin
        n_q         <= n_d;
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      req_q <= s_tuser;
      val_q <= s_tdata[DW-1:0];
    end
    if (exec) begin
      out_result_q <= result;
      out_status_q <= status;
      out_count_q  <= count_ext[swmo_pkg::COUNT_W-1:0];
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {1'b0, out_count_q, out_result_q};
  assign m_tuser  = out_status_q;

  `SWMO_ASSERT_NOW(a_count_bound, 1'b1, n_q <= CW'(CAPACITY),
    "element count above capacity")
  `SWMO_ASSERT_NEXT(a_accept_pends, s_tvalid && s_tready, pend_q && !s_tready,
    "accepted transaction not held for execution")
  `SWMO_ASSERT_NEXT(a_exec_result, exec, m_tvalid,
    "executed request produced no result")
  `SWMO_ASSERT_NEXT(a_pop_count, exec && (req_q == swmo_pkg::REQ_POP) && !empty,
    n_q == $past(nm1), "pop did not decrement the count")
  `SWMO_ASSERT_NOW(a_full_status,
    out_valid_q && (out_status_q == swmo_pkg::ST_FULL), n_q == CW'(CAPACITY),
    "full refusal without a full stack")

endmodule
